// ===== hw/rtl/rdc_pkg.sv =====
// rdc_pkg: shared types and constants for the range distinct counter
// holds field widths, default sizes, mode codes, sequencer states and the presence-map control struct
// no dependencies
package rdc_pkg;

    localparam int FIELD_W         = 10;
    localparam int COUNT_W         = 11;
    localparam int IDX_W           = 21;
    localparam int DEF_ARRAY_DEPTH = 1024;
    localparam int DEF_VALUE_COUNT = 1024;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_PRES,
        ST_MARK,
        ST_CLR,
        ST_DONE
    } rdc_state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_bit;
    } pres_ctrl_t;

endpackage

// ===== hw/rtl/range_distinct_count_with_updates_core.sv =====
// write transaction: stored at the edge that accepts it, no result
// query over n positions: each position is looked up in ST_PRES and marked in ST_MARK,
//   then the marks are cleared back position by position in ST_CLR
// query with an empty range: goes straight to ST_DONE; one transaction at a time, result held in an output register
// reset: asynchronous, active low; then the presence map is cleared one value at a time in ST_INIT, in_stall high
// depends on rdc_pkg, rdc_elem_store, rdc_presence
module range_distinct_count_with_updates_core
    import rdc_pkg::*;
#(
    parameter int ARRAY_DEPTH = DEF_ARRAY_DEPTH,
    parameter int VALUE_COUNT = DEF_VALUE_COUNT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic [FIELD_W-1:0] position,
    input  logic [FIELD_W-1:0] value,
    input  logic [FIELD_W-1:0] left_end,
    input  logic [FIELD_W-1:0] right_end,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [COUNT_W-1:0] distinct_count
);

    localparam int AW = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
    localparam int VW = (VALUE_COUNT > 1) ? $clog2(VALUE_COUNT) : 1;

    rdc_state_t         state_reg, state_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [AW-1:0]      lo_reg, lo_next;
    logic [AW-1:0]      hi_reg, hi_next;
    logic [VW-1:0]      clr_reg, clr_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] dc_reg, dc_next;

    logic [IDX_W-1:0]   pos_ext, val_ext, left_ext, right_ext, hi_clip;
    logic               in_accept, range_empty, wr_ok;

    logic               elem_wr_en, elem_rd_en;
    logic [AW-1:0]      elem_rd_addr;
    logic [VW-1:0]      elem_rd_data;
    pres_ctrl_t         pres_ctrl;
    logic [VW-1:0]      pres_addr;
    logic               pres_bit;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    assign pos_ext   = IDX_W'(position);
    assign val_ext   = IDX_W'(value);
    assign left_ext  = IDX_W'(left_end);
    assign right_ext = IDX_W'(right_end);
    assign hi_clip   = (right_ext >= IDX_W'(ARRAY_DEPTH)) ? IDX_W'(ARRAY_DEPTH - 1) : right_ext;
    assign range_empty = (left_ext > hi_clip);
    assign wr_ok     = (pos_ext < IDX_W'(ARRAY_DEPTH)) && (val_ext < IDX_W'(VALUE_COUNT));

    assign elem_wr_en = in_accept && (mode == MODE_WRITE) && wr_ok;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        clr_next       = clr_reg;
        count_next     = count_reg;
        dc_next        = dc_reg;
        out_valid_next = out_valid_reg && out_stall;
        elem_rd_en     = 1'b0;
        elem_rd_addr   = idx_reg + AW'(1);
        pres_ctrl      = '0;
        pres_addr      = elem_rd_data;

        unique case (state_reg)
            ST_INIT:
            begin
                pres_addr        = clr_reg;
                pres_ctrl.wr_en  = 1'b1;
                pres_ctrl.wr_bit = 1'b0;
                clr_next         = clr_reg + VW'(1);
                if (clr_reg == VW'(VALUE_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                elem_rd_addr = AW'(left_ext);
                if (in_accept && (mode == MODE_QUERY))
                begin
                    count_next = '0;
                    lo_next    = AW'(left_ext);
                    hi_next    = AW'(hi_clip);
                    idx_next   = AW'(left_ext);
                    if (range_empty)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        elem_rd_en = 1'b1;
                        state_next = ST_PRES;
                    end
                end
            end
            ST_PRES:
            begin
                pres_ctrl.rd_en = 1'b1;
                state_next      = ST_MARK;
            end
            ST_MARK:
            begin
                elem_rd_en = 1'b1;
                if (!pres_bit)
                begin
                    pres_ctrl.wr_en  = 1'b1;
                    pres_ctrl.wr_bit = 1'b1;
                    count_next       = count_reg + COUNT_W'(1);
                end
                if (idx_reg == hi_reg)
                begin
                    elem_rd_addr = lo_reg;
                    idx_next     = lo_reg;
                    state_next   = ST_CLR;
                end
                else
                begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = ST_PRES;
                end
            end
            ST_CLR:
            begin
                pres_ctrl.wr_en  = 1'b1;
                pres_ctrl.wr_bit = 1'b0;
                if (idx_reg == hi_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    elem_rd_en = 1'b1;
                    idx_next   = idx_reg + AW'(1);
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    dc_next        = count_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        dc_reg  <= dc_next;
    end

    assign out_valid      = out_valid_reg;
    assign distinct_count = dc_reg;

    rdc_elem_store #(
        .ARRAY_DEPTH (ARRAY_DEPTH),
        .VALUE_COUNT (VALUE_COUNT)
    ) u_elem_store (
        .clk     (clk),
        .wr_en   (elem_wr_en),
        .wr_addr (AW'(pos_ext)),
        .wr_data (VW'(val_ext)),
        .rd_en   (elem_rd_en),
        .rd_addr (elem_rd_addr),
        .rd_data (elem_rd_data)
    );

    rdc_presence #(
        .VALUE_COUNT (VALUE_COUNT)
    ) u_presence (
        .clk    (clk),
        .ctrl   (pres_ctrl),
        .addr   (pres_addr),
        .rd_bit (pres_bit)
    );

`ifndef SYNTH
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result transaction raised outside the done state");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PRES || state_reg == ST_MARK || state_reg == ST_CLR)
        |-> (idx_reg >= lo_reg && idx_reg <= hi_reg))
        else $error("walk index outside the queried range");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MARK) |-> (count_reg <= COUNT_W'(idx_reg - lo_reg)))
        else $error("running count exceeds positions visited");

    a_write_no_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && mode == MODE_WRITE) |=> (state_reg == ST_IDLE))
        else $error("write transaction started a walk");
`endif

endmodule

// ===== hw/rtl/rdc_elem_store.sv =====
// rdc_elem_store: element array, one write port and one registered read port
// depends on rdc_pkg
module rdc_elem_store
    import rdc_pkg::*;
#(
    parameter int ARRAY_DEPTH = DEF_ARRAY_DEPTH,
    parameter int VALUE_COUNT = DEF_VALUE_COUNT,
    localparam int AW = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1,
    localparam int VW = (VALUE_COUNT > 1) ? $clog2(VALUE_COUNT) : 1
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [VW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [VW-1:0] rd_data
);

    logic [VW-1:0] mem [ARRAY_DEPTH];
    logic [VW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/rdc_presence.sv =====
// rdc_presence: one bit per value, marks values already seen in the current query
// depends on rdc_pkg (pres_ctrl_t)
module rdc_presence
    import rdc_pkg::*;
#(
    parameter int VALUE_COUNT = DEF_VALUE_COUNT,
    localparam int VW = (VALUE_COUNT > 1) ? $clog2(VALUE_COUNT) : 1
)
(
    input  logic          clk,
    input  pres_ctrl_t    ctrl,
    input  logic [VW-1:0] addr,
    output logic          rd_bit
);

    logic mem [VALUE_COUNT];
    logic rd_bit_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[addr] <= ctrl.wr_bit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rd_bit_reg <= mem[addr];
        end
    end

    assign rd_bit = rd_bit_reg;

`ifndef SYNTH
    a_no_rd_wr_same_cycle: assert property (@(posedge clk) !(ctrl.rd_en && ctrl.wr_en))
        else $error("presence map read and write in one cycle");
`endif

endmodule
